### rtl/rc4_stream_cipher_top_assert.svh
// assertion macros shared by the checker
`ifndef RC4_STREAM_CIPHER_TOP_ASSERT_SVH
`define RC4_STREAM_CIPHER_TOP_ASSERT_SVH

// same-cycle implication, off while reset is held
`define RC4_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while reset is held
`define RC4_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/rc4_pkg.sv
package rc4_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned PERM_N = 256;
  localparam int unsigned KCNT_W = 9;

  // longest key held in the key store
  localparam logic [KCNT_W-1:0] KEY_MAX = 9'd256;
  localparam logic [BYTE_W-1:0] LAST_IDX = 8'hff;

  typedef enum logic {
    FUNC_KEY  = 1'b0,
    FUNC_DATA = 1'b1
  } func_t;

  typedef struct packed {
    func_t             func;
    logic              last;
    logic [BYTE_W-1:0] data;
  } cmd_t;

  typedef struct packed {
    logic vld;
    cmd_t cmd;
  } cmd_req_t;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_RD_A = 5'b00010,
    ST_RD_B = 5'b00100,
    ST_WR_A = 5'b01000,
    ST_WR_B = 5'b10000
  } core_st_t;

endpackage

### rtl/rc4_front.sv
module rc4_front import rc4_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  logic              in_func,
  input  logic [BYTE_W-1:0] in_byte_in,
  input  logic              in_key_last,
  output cmd_req_t          req,
  input  logic              req_pop
);

  logic [1:0] cnt_r, cnt_nxt;
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  cmd_t       q_r [2];
  cmd_t       cmd_in;
  logic       push_ok;
  logic       pop_ok;

  // key_last only means something on a key request
  always_comb begin
    cmd_in.func = func_t'(in_func);
    cmd_in.last = in_key_last & (cmd_in.func == FUNC_KEY);
    cmd_in.data = in_byte_in;
  end

  assign in_full = (cnt_r == 2'd2);
  assign push_ok = in_push & ~in_full;
  assign req.vld = (cnt_r != 2'd0);
  assign req.cmd = q_r[rp_r];
  assign pop_ok  = req_pop & req.vld;

  always_comb begin
    wp_nxt  = wp_r ^ push_ok;
    rp_nxt  = rp_r ^ pop_ok;
    cnt_nxt = cnt_r;
    if (push_ok && !pop_ok) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!push_ok && pop_ok) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_r[wp_r] <= cmd_in;
    end
  end

endmodule

### rtl/rc4_core.sv
module rc4_core import rc4_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_req_t          req,
  output logic              req_pop,
  input  logic              outq_full,
  output logic              res_push,
  output logic [BYTE_W-1:0] res_byte
);

  core_st_t          st_r, st_nxt;
  logic              sched_r, sched_nxt;
  logic [BYTE_W-1:0] a_r, a_nxt;
  logic [BYTE_W-1:0] i_r, i_nxt;
  logic [BYTE_W-1:0] j_r, j_nxt;
  logic [BYTE_W-1:0] kidx_r, kidx_nxt;
  logic [KCNT_W-1:0] len_r, len_nxt;
  logic [KCNT_W-1:0] key_cnt_r, key_cnt_nxt;
  logic [BYTE_W-1:0] sa_r, sa_nxt;
  logic [BYTE_W-1:0] sb_r, sb_nxt;
  logic [BYTE_W-1:0] k_r, k_nxt;
  logic [BYTE_W-1:0] byte_r, byte_nxt;
  logic [PERM_N-1:0] vld_r;

  logic [BYTE_W-1:0] perm_mem [PERM_N];
  logic [BYTE_W-1:0] key_mem  [PERM_N];
  logic [BYTE_W-1:0] pmem_q_r;
  logic              pvld_q_r;
  logic [BYTE_W-1:0] padr_q_r;
  logic [BYTE_W-1:0] kmem_q_r;

  logic [BYTE_W-1:0] prd_addr;
  logic              pwe;
  logic [BYTE_W-1:0] pwa;
  logic [BYTE_W-1:0] pwd;
  logic              kwe;
  logic [BYTE_W-1:0] kwa;
  logic              vld_clr;
  logic [BYTE_W-1:0] perm_rd;
  logic [BYTE_W-1:0] j1;
  logic [BYTE_W-1:0] kaddr;
  logic [BYTE_W-1:0] ks;
  logic [KCNT_W-1:0] cnt_inc;

  // entries not written since the last identity load read as their own index
  assign perm_rd = pvld_q_r ? pmem_q_r : padr_q_r;
  assign j1      = j_r + perm_rd + (sched_r ? kmem_q_r : '0);
  assign kaddr   = sa_r + perm_rd;
  assign cnt_inc = key_cnt_r + 9'd1;

  // keystream read went out before the swap landed, so forward the new values
  always_comb begin
    priority if (k_r == j_r) begin
      ks = sa_r;
    end else if (k_r == a_r) begin
      ks = sb_r;
    end else begin
      ks = perm_rd;
    end
  end

  assign res_byte = byte_r ^ ks;
  assign kwa      = key_cnt_r[BYTE_W-1:0];

  always_comb begin
    st_nxt      = st_r;
    sched_nxt   = sched_r;
    a_nxt       = a_r;
    i_nxt       = i_r;
    j_nxt       = j_r;
    kidx_nxt    = kidx_r;
    len_nxt     = len_r;
    key_cnt_nxt = key_cnt_r;
    sa_nxt      = sa_r;
    sb_nxt      = sb_r;
    k_nxt       = k_r;
    byte_nxt    = byte_r;
    req_pop     = 1'b0;
    res_push    = 1'b0;
    kwe         = 1'b0;
    pwe         = 1'b0;
    pwa         = a_r;
    pwd         = perm_rd;
    prd_addr    = a_r;
    vld_clr     = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        if (req.vld) begin
          if (req.cmd.func == FUNC_KEY) begin
            req_pop = 1'b1;
            if (key_cnt_r < KEY_MAX) begin
              kwe         = 1'b1;
              key_cnt_nxt = cnt_inc;
            end
            if (req.cmd.last) begin
              // schedule starts over the identity permutation
              len_nxt     = (key_cnt_r < KEY_MAX) ? cnt_inc : key_cnt_r;
              key_cnt_nxt = '0;
              vld_clr     = 1'b1;
              a_nxt       = '0;
              i_nxt       = '0;
              j_nxt       = '0;
              kidx_nxt    = '0;
              sched_nxt   = 1'b1;
              st_nxt      = ST_RD_A;
            end
          end else if (!outq_full) begin
            req_pop   = 1'b1;
            byte_nxt  = req.cmd.data;
            i_nxt     = i_r + 8'd1;
            a_nxt     = i_r + 8'd1;
            sched_nxt = 1'b0;
            st_nxt    = ST_RD_A;
          end
        end
      end
      ST_RD_A: begin
        prd_addr = a_r;
        st_nxt   = ST_RD_B;
      end
      ST_RD_B: begin
        prd_addr = j1;
        sa_nxt   = perm_rd;
        j_nxt    = j1;
        st_nxt   = ST_WR_A;
      end
      ST_WR_A: begin
        pwe      = 1'b1;
        pwa      = a_r;
        pwd      = perm_rd;
        sb_nxt   = perm_rd;
        prd_addr = kaddr;
        k_nxt    = kaddr;
        st_nxt   = ST_WR_B;
      end
      ST_WR_B: begin
        pwe = 1'b1;
        pwa = j_r;
        pwd = sa_r;
        if (sched_r) begin
          if (({1'b0, kidx_r} + 9'd1) == len_r) begin
            kidx_nxt = '0;
          end else begin
            kidx_nxt = kidx_r + 8'd1;
          end
          if (a_r == LAST_IDX) begin
            j_nxt  = '0;
            st_nxt = ST_IDLE;
          end else begin
            a_nxt  = a_r + 8'd1;
            st_nxt = ST_RD_A;
          end
        end else begin
          res_push = 1'b1;
          st_nxt   = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_IDLE;
      sched_r   <= 1'b0;
      i_r       <= '0;
      j_r       <= '0;
      key_cnt_r <= '0;
      kidx_r    <= '0;
      len_r     <= '0;
    end else begin
      st_r      <= st_nxt;
      sched_r   <= sched_nxt;
      i_r       <= i_nxt;
      j_r       <= j_nxt;
      key_cnt_r <= key_cnt_nxt;
      kidx_r    <= kidx_nxt;
      len_r     <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r    <= a_nxt;
    sa_r   <= sa_nxt;
    sb_r   <= sb_nxt;
    k_r    <= k_nxt;
    byte_r <= byte_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || vld_clr) begin
      vld_r <= '0;
    end else if (pwe) begin
      vld_r[pwa] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pwe) begin
      perm_mem[pwa] <= pwd;
    end
    pmem_q_r <= perm_mem[prd_addr];
    pvld_q_r <= vld_r[prd_addr];
    padr_q_r <= prd_addr;
  end

  always_ff @(posedge clk) begin
    if (kwe) begin
      key_mem[kwa] <= req.cmd.data;
    end
    kmem_q_r <= key_mem[kidx_r];
  end

endmodule

### rtl/rc4_outq.sv
module rc4_outq import rc4_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              res_push,
  input  logic [BYTE_W-1:0] res_byte,
  output logic              outq_full,
  output logic              out_empty,
  input  logic              out_pop,
  output logic [BYTE_W-1:0] out_byte_out
);

  logic [1:0]        cnt_r, cnt_nxt;
  logic              wp_r, wp_nxt;
  logic              rp_r, rp_nxt;
  logic [BYTE_W-1:0] q_r [2];
  logic              pop_ok;

  assign outq_full    = (cnt_r == 2'd2);
  assign out_empty    = (cnt_r == 2'd0);
  assign out_byte_out = q_r[rp_r];
  assign pop_ok       = out_pop & ~out_empty;

  // core only starts a data request when there is room, so a push never drops
  always_comb begin
    wp_nxt  = wp_r ^ res_push;
    rp_nxt  = rp_r ^ pop_ok;
    cnt_nxt = cnt_r;
    if (res_push && !pop_ok) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!res_push && pop_ok) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      q_r[wp_r] <= res_byte;
    end
  end

endmodule

### rtl/rc4_stream_cipher_top.sv
// RC4 stream cipher engine.
// Input channel (in_push / in_full) takes requests: in_func = 0 loads the key
// byte in_byte_in, and in_key_last = 1 on such a request runs the key
// schedule; in_func = 1 encrypts or decrypts in_byte_in.
// Result channel (out_empty / out_pop) gives one out_byte_out per data
// request, in request order; key requests give no result.
// A two-entry request queue separates the accepting front end from the
// cipher core, and a two-entry result queue sits behind the core.
// Data request: the core takes the next one only once the last is done, stepping
// through the single read / single write permutation memory (read S[i],
// read S[j], write S[i] and read keystream, write S[j]), then pushes the result.
// Key byte: stored when the core pops it in idle, one key byte per cycle
// while the core is idle. Final key byte: the pop, then the RD_A, RD_B,
// WR_A and WR_B states for each of the 256 schedule steps.
// Reset (synchronous, rst_n low) empties both queues, sets the permutation
// to the identity, clears i, j and the key count. No clearing pass is needed.
// When the receiver stalls, results wait in the result queue; once it is
// full the core holds and in_full rises when the request queue fills.
module rc4_stream_cipher_top import rc4_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  logic              in_func,
  input  logic [BYTE_W-1:0] in_byte_in,
  input  logic              in_key_last,
  output logic              out_empty,
  input  logic              out_pop,
  output logic [BYTE_W-1:0] out_byte_out
);

  cmd_req_t          req;
  logic              req_pop;
  logic              outq_full;
  logic              res_push;
  logic [BYTE_W-1:0] res_byte;

  rc4_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_full     (in_full),
    .in_func     (in_func),
    .in_byte_in  (in_byte_in),
    .in_key_last (in_key_last),
    .req         (req),
    .req_pop     (req_pop)
  );

  rc4_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req),
    .req_pop   (req_pop),
    .outq_full (outq_full),
    .res_push  (res_push),
    .res_byte  (res_byte)
  );

  rc4_outq u_outq (
    .clk          (clk),
    .rst_n        (rst_n),
    .res_push     (res_push),
    .res_byte     (res_byte),
    .outq_full    (outq_full),
    .out_empty    (out_empty),
    .out_pop      (out_pop),
    .out_byte_out (out_byte_out)
  );

endmodule

### rtl/rc4_chk.sv
`include "rc4_stream_cipher_top_assert.svh"

module rc4_chk import rc4_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_push,
  input logic              in_full,
  input logic              out_empty,
  input logic              out_pop,
  input logic [BYTE_W-1:0] out_byte_out
);

  // nothing left over from before reset
  `RC4_ASSERT_IMP(a_rst_empty, !$past(rst_n), out_empty && !in_full, "queues not empty after reset")

  // the request queue only fills on an accepted request
  `RC4_ASSERT_NXT(a_full_by_push, !in_full && !in_push, !in_full, "in_full rose without a request")

  // results only leave on a pop
  `RC4_ASSERT_NXT(a_res_kept, !out_empty && !out_pop, !out_empty, "result lost without a pop")

  // a waiting result holds its value
  `RC4_ASSERT_NXT(a_res_hold, !out_empty && !out_pop, $stable(out_byte_out), "stalled result changed")

endmodule

bind rc4_stream_cipher_top rc4_chk u_chk (.*);

### sim/tb_top.sv
module tb_top;
  import rc4_pkg::*;

  localparam int N_ITEMS     = 1850;
  localparam int N_DIR       = 21;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN       = 1100;
  localparam int WDOG_LIMIT  = 5000;

  typedef struct packed {
    func_t             func;
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              chk;
    logic [BYTE_W-1:0] want;
  } vec_t;

  logic              clk;
  logic              rst_n;
  logic              in_push;
  logic              in_full;
  logic              in_func;
  logic [BYTE_W-1:0] in_byte_in;
  logic              in_key_last;
  logic              out_empty;
  logic              out_pop;
  logic [BYTE_W-1:0] out_byte_out;

  // predictor state
  logic [BYTE_W-1:0] sbox    [PERM_N];
  logic [BYTE_W-1:0] key_mem [PERM_N];
  logic [KCNT_W-1:0] key_len;
  logic [BYTE_W-1:0] idx_i;
  logic [BYTE_W-1:0] idx_j;

  logic [BYTE_W-1:0] pending_bytes [$];
  vec_t              dir_vec [N_DIR];

  int  n_errors  = 0;
  int  n_items   = 0;
  int  n_data    = 0;
  int  n_rekeys  = 0;
  int  n_dropped = 0;
  bit  tx_idle   = 0;
  bit  rx_idle   = 0;
  bit  hold_req  = 0;

  rc4_stream_cipher_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_full     (in_full),
    .in_func     (in_func),
    .in_byte_in  (in_byte_in),
    .in_key_last (in_key_last),
    .out_empty   (out_empty),
    .out_pop     (out_pop),
    .out_byte_out(out_byte_out)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task load_identity();
    for (int n = 0; n < PERM_N; n++) sbox[n] = n[BYTE_W-1:0];
  endtask

  task rc4_predict(input func_t f, input logic [BYTE_W-1:0] b, input logic last,
                   output logic has, output logic [BYTE_W-1:0] ob);
    logic [BYTE_W-1:0] t;
    logic [BYTE_W-1:0] k;
    logic [BYTE_W-1:0] j8;
    int                len;
    has = 1'b0;
    ob  = '0;
    if (f == FUNC_KEY) begin
      if (key_len < KEY_MAX) begin
        key_mem[key_len[BYTE_W-1:0]] = b;
        key_len = key_len + 1'b1;
      end else begin
        n_dropped++;
      end
      if (last) begin
        len = (key_len == '0) ? 1 : int'(key_len);
        j8  = '0;
        load_identity();
        for (int n = 0; n < PERM_N; n++) begin
          j8 = j8 + sbox[n] + key_mem[n % len];
          t = sbox[n];
          sbox[n] = sbox[j8];
          sbox[j8] = t;
        end
        idx_i   = '0;
        idx_j   = '0;
        key_len = '0;
        n_rekeys++;
      end
    end else begin
      idx_i = idx_i + 1'b1;
      idx_j = idx_j + sbox[idx_i];
      t = sbox[idx_i];
      sbox[idx_i] = sbox[idx_j];
      sbox[idx_j] = t;
      k   = sbox[idx_i] + sbox[idx_j];
      ob  = b ^ sbox[k];
      has = 1'b1;
      n_data++;
    end
  endtask

  // offer one request, wait for it to be taken, then maybe leave a gap
  task automatic push_request(input func_t f, input logic [BYTE_W-1:0] b,
                              input logic last, input logic chk = 1'b0,
                              input logic [BYTE_W-1:0] want = '0);
    logic              has;
    logic [BYTE_W-1:0] ob;
    in_push     <= 1'b1;
    in_func     <= f;
    in_byte_in  <= b;
    in_key_last <= last;
    @(posedge clk);
    while (in_full) @(posedge clk);
    if (!(f == FUNC_KEY && key_len >= KEY_MAX && !last)) n_items++;
    rc4_predict(f, b, last, has, ob);
    if (has) pending_bytes.push_back(chk ? want : ob);
    if (tx_idle && $urandom_range(0, 7) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  task automatic push_key(input int len);
    for (int n = 0; n < len; n++) push_request(FUNC_KEY, 8'($urandom), n == len - 1);
  endtask

  task automatic push_data(input int cnt);
    for (int n = 0; n < cnt; n++) push_request(FUNC_DATA, 8'($urandom), 1'($urandom));
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (pending_bytes.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %02h", $time, out_byte_out);
        n_errors++;
      end else begin
        if (out_byte_out !== pending_bytes[0]) begin
          $display("%0t: byte_out mismatch, expected %02h, actual %02h",
                   $time, pending_bytes[0], out_byte_out);
          n_errors++;
        end
        void'(pending_bytes.pop_front());
      end
    end
  end

  // receiver
  initial begin
    out_pop = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (rx_idle && $urandom_range(0, 9) == 0) begin
        out_pop <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        out_pop <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // watchdog: cycles with no request or result taken
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WDOG_LIMIT) begin
      @(posedge clk);
      if ((in_push && !in_full) || (out_pop && !out_empty)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("%0t: no progress for %0d cycles, %0d results outstanding",
             $time, WDOG_LIMIT, pending_bytes.size());
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    int seq;
    int kind;
    int len;
    bit tail;
    rst_n       = 1'b0;
    in_push     = 1'b0;
    in_func     = 1'b0;
    in_byte_in  = '0;
    in_key_last = 1'b0;
    load_identity();
    key_len = '0;
    idx_i   = '0;
    idx_j   = '0;
    for (int n = 0; n < PERM_N; n++) key_mem[n] = '0;

    dir_vec = '{
      // identity permutation after reset
      '{FUNC_DATA, 8'h00, 1'b0, 1'b1, 8'h02},
      '{FUNC_DATA, 8'hff, 1'b1, 1'b1, 8'hfa},
      // one-byte key of the lowest value, then the highest byte starts a two-byte key
      '{FUNC_KEY,  8'h00, 1'b1, 1'b0, 8'h00},
      '{FUNC_DATA, 8'h00, 1'b0, 1'b0, 8'h00},
      '{FUNC_DATA, 8'hff, 1'b1, 1'b0, 8'h00},
      '{FUNC_KEY,  8'hff, 1'b0, 1'b0, 8'h00},
      // data while a key is half loaded
      '{FUNC_DATA, 8'h3c, 1'b0, 1'b0, 8'h00},
      '{FUNC_KEY,  8'h01, 1'b1, 1'b0, 8'h00},
      '{FUNC_DATA, 8'h80, 1'b0, 1'b0, 8'h00},
      // textbook vector: key "Key", text "Plaintext"
      '{FUNC_KEY,  8'h4b, 1'b0, 1'b0, 8'h00},
      '{FUNC_KEY,  8'h65, 1'b0, 1'b0, 8'h00},
      '{FUNC_KEY,  8'h79, 1'b1, 1'b0, 8'h00},
      '{FUNC_DATA, 8'h50, 1'b0, 1'b1, 8'hbb},
      '{FUNC_DATA, 8'h6c, 1'b0, 1'b1, 8'hf3},
      '{FUNC_DATA, 8'h61, 1'b0, 1'b1, 8'h16},
      '{FUNC_DATA, 8'h69, 1'b0, 1'b1, 8'he8},
      '{FUNC_DATA, 8'h6e, 1'b0, 1'b1, 8'hd9},
      '{FUNC_DATA, 8'h74, 1'b0, 1'b1, 8'h40},
      '{FUNC_DATA, 8'h65, 1'b0, 1'b1, 8'haf},
      '{FUNC_DATA, 8'h78, 1'b0, 1'b1, 8'h0a},
      '{FUNC_DATA, 8'h74, 1'b0, 1'b1, 8'hd3}
    };

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_idle = 1'b1;
    rx_idle = 1'b1;
    for (int n = 0; n < N_DIR; n++)
      push_request(dir_vec[n].func, dir_vec[n].data, dir_vec[n].last,
                   dir_vec[n].chk, dir_vec[n].want);

    seq = 0;
    while (n_items < N_ITEMS) begin
      tail    = (n_items >= N_ITEMS - 150);
      tx_idle = !tail && ($urandom_range(0, 3) != 0);
      rx_idle = !tail && ($urandom_range(0, 3) != 0);
      kind    = $urandom_range(0, 99);
      if (seq == 4) begin
        // receiver holds off while the sender keeps going, so in_full rises
        tx_idle  = 1'b0;
        hold_req = 1'b1;
        push_data(24);
      end else if (seq == 8) begin
        in_push <= 1'b0;
        @(posedge clk);
        while (pending_bytes.size() != 0) @(posedge clk);
      end else if (kind < 75 || seq == 2 || seq == 3) begin
        if (seq == 2) len = 256;
        else if (seq == 3) len = 260;
        else if ($urandom_range(0, 3) == 0) len = $urandom_range(9, 32);
        else len = $urandom_range(1, 8);
        push_key(len);
        push_data($urandom_range(4, 40));
      end else if (kind < 85) begin
        push_data($urandom_range(1, 30));
      end else if (kind < 93) begin
        // key interrupted by data, then finished
        len = $urandom_range(1, 5);
        for (int n = 0; n < len; n++) push_request(FUNC_KEY, 8'($urandom), 1'b0);
        push_data($urandom_range(1, 6));
        push_key($urandom_range(1, 4));
      end else begin
        len = $urandom_range(1, 8);
        for (int n = 0; n < len; n++)
          push_request(func_t'($urandom_range(0, 1)), 8'($urandom),
                       $urandom_range(0, 3) == 0);
      end
      seq++;
    end

    in_push <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("covered %0d requests in %0d sequences: %0d data bytes, %0d key schedules",
             n_items, seq, n_data, n_rekeys);
    $display("keys of 1 to 260 bytes, %0d key bytes past the store limit, full-queue stall",
             n_dropped);
    if (n_errors == 0 && pending_bytes.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
